[hw/rtl/arms_pkg.sv]
// Package for the arm reach metrics smoother: widths, sequencer states, shared-unit ops.
// No dependencies.
package arms_pkg;
  localparam int COORD_BITS_DEF = 14;
  localparam int WEIGHT_FRAC_BITS_DEF = 8;
  localparam int NUM_JOINTS = 7;
  localparam int DIST_BITS = 16;
  localparam int EXT_FRAC = 12;
  localparam int EXT_BITS = 13;
  localparam int JOINT_BITS = 3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_SQ, ST_ROOT, ST_SMOOTH, ST_DIV, ST_HEAD, ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;
endpackage

[hw/rtl/arms_sqrt.sv]
// Iterative unit: square root of a sum of squares, and restoring divide,
// one result bit per cycle. No dependencies.
module arms_sqrt #(
  parameter int W = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          div_mode,
  input  logic [W-1:0]  opa,
  input  logic [W-1:0]  opb,
  output logic          busy,
  output logic          done,
  output logic [W-1:0]  res
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem;
  logic [W-1:0] acc;
  logic [W-1:0] bitv;
  logic [W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          mode;
  logic [W:0]    trial;

  always_comb begin
    if (mode) begin
      trial = {rem[W-2:0], acc[W-1]} - {1'b0, dvs};
    end else begin
      trial = {1'b0, rem} - {1'b0, acc + bitv};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        mode <= div_mode;
        cnt  <= div_mode ? CW'(W) : CW'(W / 2);
        if (div_mode) begin
          rem <= '0;
          acc <= opa;
          dvs <= opb;
        end else begin
          rem  <= opa;
          acc  <= '0;
          bitv <= W'(1) << (2 * ((W - 1) / 2));
        end
      end else if (busy) begin
        if (mode) begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            acc <= {acc[W-2:0], 1'b1};
          end else begin
            rem <= {rem[W-2:0], acc[W-1]};
            acc <= {acc[W-2:0], 1'b0};
          end
        end else begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            acc <= (acc >> 1) + bitv;
          end else begin
            acc <= acc >> 1;
          end
          bitv <= bitv >> 2;
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = acc;

  ap_done_one: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  ap_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("no busy after start");
  ap_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("count underflow");
endmodule

[hw/rtl/arm_reach_metrics_smoother.sv]
// Top level: joint store, frame sequencer and result register.
// Depends on arms_pkg and arms_sqrt.
//
// Joints are taken one item per cycle while idle. An item with frame_end set
// starts the frame update: six distances (squares summed over the three axes,
// then a 24-step square root) and two 48-step divides on the shared iterative
// unit; the divide for an arm whose average is zero is skipped. s_axis_tready
// stays low from a frame-end item until the sequencer is idle again. The result
// item waits in an output register; the next item is accepted while it waits. A
// frame end that finishes while an earlier result still waits holds in its last step until the register frees.
module arm_reach_metrics_smoother #(
  parameter int COORD_BITS = arms_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = arms_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // joint[2:0], pos_x, pos_y, pos_z, zero pad
  input  logic [((3 + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic s_axis_tlast,   // frame_end
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [WEIGHT_FRAC_BITS:0] cfg_data,  // smooth_weight
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // arm_length_right, arm_length_left, reach_right, reach_left,
  // extension_right, extension_left, head_depth, zero pad
  output logic [((4 * 16 + 26 + COORD_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  localparam int CB = COORD_BITS;
  localparam int F = WEIGHT_FRAC_BITS;
  localparam int OW = ((4 * 16 + 26 + CB + 7) / 8) * 8;
  localparam int UW = 48;
  localparam int SQW = 2 * CB + 2;
  localparam logic [F:0] WONE = (F + 1)'(1) << F;

  logic signed [CB-1:0] jx [arms_pkg::NUM_JOINTS];
  logic signed [CB-1:0] jy [arms_pkg::NUM_JOINTS];
  logic signed [CB-1:0] jz [arms_pkg::NUM_JOINTS];
  logic [F:0] weight;
  logic [15:0] arm_avg [2];
  logic [15:0] rch_avg [2];
  logic signed [CB-1:0] head_avg;
  logic [12:0] ext [2];

  arms_pkg::seq_state_t state, state_next;
  logic [2:0] idx;       // distance 0..5 or divide 0..1
  logic [1:0] axis;
  logic [UW-1:0] sumsq;
  logic [16:0] dists [6];
  logic unit_start, unit_mode, unit_busy, unit_done;
  logic [UW-1:0] unit_a, unit_b, unit_res;

  wire [2:0] jsel = s_axis_tdata[2:0];
  wire in_acc = s_axis_tvalid && s_axis_tready;
  wire out_free = !m_axis_tvalid || m_axis_tready;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == arms_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= (F + 1)'(128);
      for (int i = 0; i < arms_pkg::NUM_JOINTS; i++) begin
        jx[i] <= '0; jy[i] <= '0; jz[i] <= '0;
      end
    end else begin
      if (cfg_valid) weight <= cfg_data;
      if (in_acc && jsel != 3'd7) begin
        jx[jsel] <= s_axis_tdata[3 +: CB];
        jy[jsel] <= s_axis_tdata[3 + CB +: CB];
        jz[jsel] <= s_axis_tdata[3 + 2 * CB +: CB];
      end
    end
  end

  // distance pair select: side*3 + {0-1, 1-2, 0-2}
  logic [2:0] pa, pb;
  always_comb begin
    case (idx)
      3'd0: begin pa = 3'd0; pb = 3'd1; end
      3'd1: begin pa = 3'd1; pb = 3'd2; end
      3'd2: begin pa = 3'd0; pb = 3'd2; end
      3'd3: begin pa = 3'd3; pb = 3'd4; end
      3'd4: begin pa = 3'd4; pb = 3'd5; end
      default: begin pa = 3'd3; pb = 3'd5; end
    endcase
  end

  logic signed [CB:0] dd;
  always_comb begin
    case (axis)
      2'd0: dd = (CB + 1)'(jx[pa]) - (CB + 1)'(jx[pb]);
      2'd1: dd = (CB + 1)'(jy[pa]) - (CB + 1)'(jy[pb]);
      default: dd = (CB + 1)'(jz[pa]) - (CB + 1)'(jz[pb]);
    endcase
  end
  wire signed [SQW-1:0] dde = SQW'(dd);
  wire [SQW-1:0] sq = $unsigned(dde * dde);

  wire [F:0] weff = (weight > WONE) ? WONE : weight;
  wire [F:0] wcomp = WONE - weff;
  wire [16:0] arm_sum0 = dists[0] + dists[1];
  wire [16:0] arm_sum1 = dists[3] + dists[4];
  wire [15:0] arm_in0 = arm_sum0[16] ? 16'hFFFF : arm_sum0[15:0];
  wire [15:0] arm_in1 = arm_sum1[16] ? 16'hFFFF : arm_sum1[15:0];

  function automatic logic [15:0] smu(input logic [15:0] o, input logic [15:0] x,
                                      input logic [F:0] w, input logic [F:0] c);
    logic [16+F+1:0] s;
    s = (16 + F + 2)'(o) * (16 + F + 2)'(w) + (16 + F + 2)'(x) * (16 + F + 2)'(c)
        + ((16 + F + 2)'(1) << (F - 1));
    return 16'(s >> F);
  endfunction

  logic signed [CB+F+2:0] hs;
  always_comb begin
    hs = (CB + F + 3)'(head_avg) * $signed({1'b0, weff})
       + (CB + F + 3)'(jz[6]) * $signed({1'b0, wcomp})
       + $signed((CB + F + 3)'(1) << (F - 1));
  end

  always_comb begin
    state_next = state;
    unit_start = 1'b0;
    unit_mode  = 1'b0;
    unit_a     = sumsq;
    unit_b     = '0;
    case (state)
      arms_pkg::ST_IDLE: if (in_acc && s_axis_tlast) state_next = arms_pkg::ST_LOAD;
      arms_pkg::ST_LOAD: state_next = arms_pkg::ST_SQ;
      arms_pkg::ST_SQ: if (axis == 2'd2) state_next = arms_pkg::ST_ROOT;
      arms_pkg::ST_ROOT: begin
        unit_start = !unit_busy && !unit_done;
        if (unit_done) state_next = (idx == 3'd5) ? arms_pkg::ST_SMOOTH : arms_pkg::ST_SQ;
      end
      arms_pkg::ST_SMOOTH: state_next = arms_pkg::ST_DIV;
      arms_pkg::ST_DIV: begin
        unit_mode  = 1'b1;
        unit_a     = UW'(rch_avg[idx[0]]) << arms_pkg::EXT_FRAC;
        unit_b     = UW'(arm_avg[idx[0]]);
        unit_start = !unit_busy && !unit_done && arm_avg[idx[0]] != 16'd0;
        if (unit_done || arm_avg[idx[0]] == 16'd0) begin
          if (idx[0]) state_next = arms_pkg::ST_HEAD;
        end
      end
      arms_pkg::ST_HEAD: state_next = arms_pkg::ST_DONE;
      arms_pkg::ST_DONE: if (out_free) state_next = arms_pkg::ST_IDLE;
      default: state_next = arms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= arms_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; axis <= '0;
      arm_avg[0] <= '0; arm_avg[1] <= '0;
      rch_avg[0] <= '0; rch_avg[1] <= '0;
      head_avg <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == arms_pkg::ST_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        arms_pkg::ST_LOAD: begin idx <= '0; axis <= '0; sumsq <= '0; end
        arms_pkg::ST_SQ: begin
          sumsq <= sumsq + UW'(sq);
          axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
        arms_pkg::ST_ROOT: if (unit_done) begin
          dists[idx] <= (unit_res > UW'(16'hFFFF)) ? 17'h0FFFF : 17'(unit_res);
          idx <= idx + 3'd1;
          sumsq <= '0;
        end
        arms_pkg::ST_SMOOTH: begin
          arm_avg[0] <= smu(arm_avg[0], arm_in0, weff, wcomp);
          arm_avg[1] <= smu(arm_avg[1], arm_in1, weff, wcomp);
          rch_avg[0] <= smu(rch_avg[0], dists[2][15:0], weff, wcomp);
          rch_avg[1] <= smu(rch_avg[1], dists[5][15:0], weff, wcomp);
          idx <= '0;
        end
        arms_pkg::ST_DIV: begin
          if (arm_avg[idx[0]] == 16'd0) begin
            ext[idx[0]] <= '0; idx <= idx + 3'd1;
          end else if (unit_done) begin
            ext[idx[0]] <= (unit_res > UW'(4096)) ? 13'd4096 : 13'(unit_res);
            idx <= idx + 3'd1;
          end
        end
        arms_pkg::ST_HEAD: head_avg <= CB'(hs >>> F);
        arms_pkg::ST_DONE: if (out_free) begin
          m_axis_tdata <= OW'({head_avg, ext[1], ext[0], rch_avg[1], rch_avg[0],
                              arm_avg[1], arm_avg[0]});
        end
        default: ;
      endcase
    end
  end

  arms_sqrt #(.W(UW)) u_unit (
    .clk(clk), .rst(rst), .start(unit_start), .div_mode(unit_mode),
    .opa(unit_a), .opb(unit_b), .busy(unit_busy), .done(unit_done), .res(unit_res)
  );

  ap_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    (state != arms_pkg::ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  ap_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == arms_pkg::ST_DONE) |=> m_axis_tvalid) else $error("result lost");
  ap_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == arms_pkg::ST_IDLE) |-> !unit_busy) else $error("unit busy in idle");
endmodule
